// ----- src/hpp_pkg.sv -----
// ----------------------------------------------------------------------------
// Hyphenation pattern parser package
// Character codes, parse phases, result kinds, beat structs and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package hpp_pkg;

    localparam logic [15:0] CH_SLASH = 16'h002F;
    localparam logic [15:0] CH_EQUAL = 16'h003D;
    localparam logic [15:0] CH_COMMA = 16'h002C;
    localparam logic [15:0] CH_ZERO  = 16'h0030;
    localparam logic [15:0] CH_NINE  = 16'h0039;

    localparam logic [2:0] PH_KEY   = 3'd0;
    localparam logic [2:0] PH_PRE   = 3'd1;
    localparam logic [2:0] PH_POST  = 3'd2;
    localparam logic [2:0] PH_START = 3'd3;
    localparam logic [2:0] PH_CUT   = 3'd4;
    localparam logic [2:0] PH_STOP  = 3'd5;

    localparam logic [1:0] KIND_KEY  = 2'd0;
    localparam logic [1:0] KIND_PRE  = 2'd1;
    localparam logic [1:0] KIND_POST = 2'd2;
    localparam logic [1:0] KIND_SUM  = 2'd3;

    localparam logic [7:0] SAT_MAX = 8'd255;

    typedef struct packed {
        logic [15:0] ch;
        logic        last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] out_char;
        logic [7:0]  prio;
        logic [6:0]  key_length;
        logic [6:0]  kept_count;
        logic [6:0]  delete_before;
        logic [7:0]  skip_after;
        logic        nonstandard;
        logic        overflow;
        logic        end_mark;
    } t_out_item;

    typedef struct packed {
        logic accept;
        logic prep;
        logic rd;
        logic chk;
        logic sum;
    } t_dp_cmd;

    typedef struct packed {
        logic walk_go;
        logic hit_odd;
    } t_dp_sts;

    function automatic logic is_digit(logic [15:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] acc_dec(logic [7:0] v, logic [15:0] c);
        logic [11:0] r;
        r = ({4'b0000, v} << 3) + ({4'b0000, v} << 1) + {8'h00, c[3:0]};
        return (r > {4'b0000, SAT_MAX}) ? SAT_MAX : r[7:0];
    endfunction

endpackage

// ----- src/hpp_ctrl.sv -----
// ----------------------------------------------------------------------------
// Hyphenation pattern parser controller
// Takes characters while idle; after the last one, sequences the summary
// setup, the delete-count walk over the priority store and the summary beat.
// ----------------------------------------------------------------------------
module hpp_ctrl
    import hpp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  logic    i_last,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_SUM  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    if (i_last) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = S_RD;
            end
            S_RD: begin
                if (i_sts.walk_go) begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_CHK;
                end else begin
                    n_state = S_SUM;
                end
            end
            S_CHK: begin
                o_cmd.chk = 1'b1;
                n_state   = i_sts.hit_odd ? S_SUM : S_RD;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

endmodule

// ----- src/hpp_datapath.sv -----
// ----------------------------------------------------------------------------
// Hyphenation pattern parser datapath
// Parse state, priority parity store, delete-count walk registers and the
// registered result beat.
// ----------------------------------------------------------------------------
module hpp_datapath
    import hpp_pkg::*;
#(
    parameter int MAX_LETTERS = 64
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_dp_cmd   i_cmd,
    input  t_in_item  i_data,
    output t_dp_sts   o_sts,
    output logic      o_strobe,
    output t_out_item o_result
);

    localparam int CW = $clog2(MAX_LETTERS + 2);
    localparam int AW = $clog2(MAX_LETTERS);
    localparam int JW = ((CW > 8) ? CW : 8) + 1;

    logic [2:0]    r_phase, n_phase;
    logic [7:0]    r_rp, n_rp;
    logic [CW-1:0] r_lc, n_lc;
    logic [CW-1:0] r_lnz, n_lnz;
    logic [7:0]    r_start, n_start;
    logic [7:0]    r_cut, n_cut;
    logic          r_ovf, n_ovf;
    logic [7:0]    r_final, n_final;
    logic          r_ns, n_ns;
    logic [JW-1:0] r_j, n_j;
    logic [JW-1:0] r_end, n_end;
    logic [CW-1:0] r_del, n_del;
    logic [7:0]    r_skip, n_skip;
    logic          r_strobe, n_strobe;
    t_out_item     r_result, n_result;
    logic          r_rd_bit;

    logic          r_par_mem [MAX_LETTERS];
    logic          w_we;
    logic [AW-1:0] w_waddr;
    logic          w_wbit;
    logic [JW-1:0] w_jm1;
    logic [AW-1:0] w_raddr;

    logic          w_fk;
    logic [JW-1:0] w_diff;
    logic          w_lc_ge;
    logic [7:0]    w_cutv;
    logic [7:0]    w_startv;
    logic          w_ns;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_KEY;
            r_rp     <= '0;
            r_lc     <= '0;
            r_lnz    <= '0;
            r_start  <= '0;
            r_cut    <= '0;
            r_ovf    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_rp     <= n_rp;
            r_lc     <= n_lc;
            r_lnz    <= n_lnz;
            r_start  <= n_start;
            r_cut    <= n_cut;
            r_ovf    <= n_ovf;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_final  <= n_final;
        r_ns     <= n_ns;
        r_j      <= n_j;
        r_end    <= n_end;
        r_del    <= n_del;
        r_skip   <= n_skip;
        r_result <= n_result;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_par_mem[w_waddr] <= w_wbit;
        end
    end

    assign w_jm1   = r_j - JW'(1);
    assign w_raddr = w_jm1[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_bit <= r_par_mem[w_raddr];
        end
    end

    assign w_diff   = JW'(r_lc) - JW'(r_start);
    assign w_lc_ge  = (JW'(r_lc) >= JW'(r_start));
    assign w_ns     = (r_phase != PH_KEY);
    assign w_startv = (r_start == '0) ? 8'd1 : r_start;

    always_comb begin
        if ((r_phase == PH_PRE) || (r_phase == PH_POST) || (r_phase == PH_START)) begin
            if (!w_lc_ge) begin
                w_cutv = '0;
            end else if (w_diff > JW'(SAT_MAX)) begin
                w_cutv = SAT_MAX;
            end else begin
                w_cutv = w_diff[7:0];
            end
        end else begin
            w_cutv = r_cut;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_rp     = r_rp;
        n_lc     = r_lc;
        n_lnz    = r_lnz;
        n_start  = r_start;
        n_cut    = r_cut;
        n_ovf    = r_ovf;
        n_final  = r_final;
        n_ns     = r_ns;
        n_j      = r_j;
        n_end    = r_end;
        n_del    = r_del;
        n_skip   = r_skip;
        n_strobe = 1'b0;
        n_result = r_result;
        w_we     = 1'b0;
        w_waddr  = '0;
        w_wbit   = 1'b0;
        w_fk     = 1'b0;

        if (i_cmd.accept) begin
            unique case (r_phase)
                PH_KEY: begin
                    if (i_data.ch == CH_SLASH) begin
                        w_fk    = 1'b1;
                        n_phase = PH_PRE;
                    end else if (is_digit(i_data.ch)) begin
                        n_rp = acc_dec(r_rp, i_data.ch);
                    end else begin
                        n_strobe          = 1'b1;
                        n_result          = '0;
                        n_result.kind     = KIND_KEY;
                        n_result.out_char = i_data.ch;
                        n_result.prio     = r_rp;
                        if (r_lc < CW'(MAX_LETTERS)) begin
                            w_we    = 1'b1;
                            w_waddr = r_lc[AW-1:0];
                            w_wbit  = r_rp[0];
                            if (r_rp != '0) begin
                                n_lnz = r_lc + CW'(1);
                            end
                            n_lc = r_lc + CW'(1);
                        end else begin
                            n_ovf = 1'b1;
                        end
                        n_rp = '0;
                    end
                end
                PH_PRE: begin
                    if (i_data.ch == CH_EQUAL) begin
                        n_phase = PH_POST;
                    end else begin
                        n_strobe          = 1'b1;
                        n_result          = '0;
                        n_result.kind     = KIND_PRE;
                        n_result.out_char = i_data.ch;
                    end
                end
                PH_POST: begin
                    if (i_data.ch == CH_COMMA) begin
                        n_phase = PH_START;
                    end else begin
                        n_strobe          = 1'b1;
                        n_result          = '0;
                        n_result.kind     = KIND_POST;
                        n_result.out_char = i_data.ch;
                    end
                end
                PH_START: begin
                    if (i_data.ch == CH_COMMA) begin
                        n_phase = PH_CUT;
                    end else if (is_digit(i_data.ch)) begin
                        n_start = acc_dec(r_start, i_data.ch);
                    end
                end
                PH_CUT: begin
                    if (is_digit(i_data.ch)) begin
                        n_cut = acc_dec(r_cut, i_data.ch);
                    end else begin
                        n_phase = PH_STOP;
                    end
                end
                default: begin
                end
            endcase
            if (i_data.last && (n_phase == PH_KEY)) begin
                w_fk = 1'b1;
            end
            if (w_fk) begin
                n_final = n_rp;
                if (n_rp != '0) begin
                    n_lnz = n_lc + CW'(1);
                end
                n_rp = '0;
            end
        end

        if (i_cmd.prep) begin
            n_ns   = w_ns;
            n_j    = JW'(w_startv);
            n_end  = JW'(w_startv) + JW'(w_cutv);
            n_del  = '0;
            n_skip = w_ns ? w_cutv : 8'd0;
        end

        if (i_cmd.chk && !r_rd_bit) begin
            n_del  = r_del + CW'(1);
            n_skip = r_skip - 8'd1;
            n_j    = r_j + JW'(1);
        end

        if (i_cmd.sum) begin
            n_strobe               = 1'b1;
            n_result               = '0;
            n_result.kind          = KIND_SUM;
            n_result.prio          = r_final;
            n_result.key_length    = 7'(r_lc);
            n_result.kept_count    = 7'(r_lnz);
            n_result.delete_before = 7'(r_del);
            n_result.skip_after    = r_skip;
            n_result.nonstandard   = r_ns;
            n_result.overflow      = r_ovf;
            n_result.end_mark      = 1'b1;
            n_phase                = PH_KEY;
            n_rp                   = '0;
            n_lc                   = '0;
            n_lnz                  = '0;
            n_start                = '0;
            n_cut                  = '0;
            n_ovf                  = 1'b0;
        end
    end

    assign o_sts.walk_go = r_ns && (r_j < r_end) && (r_j < JW'(r_lnz));
    assign o_sts.hit_odd = r_rd_bit;
    assign o_strobe      = r_strobe;
    assign o_result      = r_result;

endmodule

// ----- src/hyphenation_pattern_parser.sv -----
// ----------------------------------------------------------------------------
// Hyphenation pattern parser
// Parses one pattern character per beat into key letters with priorities,
// insert texts and a closing summary beat.
// ----------------------------------------------------------------------------
// A character is taken on any cycle with start high and busy low, one per
// cycle while busy stays low; a key letter or insert character appears on
// o_result with o_strobe the cycle after it is taken. The beat marked last
// raises busy for the summary setup and the delete-count walk, which visits
// fewer entries than the kept priority count: each visited entry costs one
// read of the priority store and one check. The walk stops on an odd
// priority or, after a final pass through the read state, when it runs out
// of entries; a standard pattern visits no entries. The summary beat
// appears in the first cycle with busy low. Results cannot be stalled, so a
// receiver must take every strobed beat.
module hyphenation_pattern_parser
    import hpp_pkg::*;
#(
    parameter int MAX_LETTERS = 64
)
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    output logic      busy,
    input  t_in_item  i_data,
    output logic      o_strobe,
    output t_out_item o_result
);

    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    hpp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_last  (i_data.last),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .busy    (busy)
    );

    hpp_datapath #(
        .MAX_LETTERS (MAX_LETTERS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_data   (i_data),
        .o_sts    (w_sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    a_last_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_data.last |=> busy)
        else $error("last beat did not start the summary sequence");

    a_char_follows_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_result.end_mark |-> $past(start && !busy))
        else $error("character beat without a preceding accept");

    a_standard_summary: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_result.end_mark && !o_result.nonstandard
            |-> (o_result.delete_before == '0) && (o_result.skip_after == '0))
        else $error("standard pattern summary carries delete or skip counts");

endmodule

// ----- tb/hyphenation_pattern_parser_tb.sv -----
// ----------------------------------------------------------------------------
// Hyphenation pattern parser testbench
// Feeds pattern characters through the start/busy command port, tracks the
// parse in a local model and checks every strobed result beat against it.
// ----------------------------------------------------------------------------
module hyphenation_pattern_parser_tb
    import hpp_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LET   = 64;
    localparam int TAIL_LEN  = 40;

    logic      i_clk   = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start   = 1'b0;
    t_in_item  i_data  = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    t_in_item    pend_chars[$];
    logic [15:0] pat_q[$];
    t_out_item   exp_beats[$];
    int          n_err   = 0;
    int          n_taken = 0;
    int          gap_pct = 20;
    int          gap     = 0;

    logic [2:0]  m_phase = PH_KEY;
    logic [7:0]  m_prio  = '0;
    logic [7:0]  m_start = '0;
    logic [7:0]  m_cut   = '0;
    logic        m_ovf   = 1'b0;
    int          m_nlet  = 0;
    int          m_kept  = 0;
    logic [7:0]  m_pmem [0:MAX_LET];

    hyphenation_pattern_parser #(
        .MAX_LETTERS(MAX_LET)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_data  (i_data),
        .o_strobe(o_strobe),
        .o_result(o_result)
    );

    always #4ns i_clk = ~i_clk;

    function automatic logic is_num(logic [15:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] dec_step(logic [7:0] v, logic [15:0] c);
        int r;
        r = int'(v) * 10 + int'(c - CH_ZERO);
        return (r > 255) ? 8'd255 : r[7:0];
    endfunction

    function automatic void push_beat(logic [1:0] k, logic [15:0] c, logic [7:0] p);
        t_out_item r;
        r          = '0;
        r.kind     = k;
        r.out_char = c;
        r.prio     = p;
        exp_beats.insert(exp_beats.size(), r);
    endfunction

    function automatic void close_key();
        int idx;
        idx         = (m_nlet > MAX_LET) ? MAX_LET : m_nlet;
        m_pmem[idx] = m_prio;
        if (m_prio != 0) m_kept = idx + 1;
        m_prio = '0;
    endfunction

    function automatic void parse_char(t_in_item it);
        t_out_item r;
        int        st;
        int        ct;
        int        j;
        int        del;
        int        skp;
        logic      ns;
        case (m_phase)
            PH_KEY: begin
                if (it.ch == CH_SLASH) begin
                    close_key();
                    m_phase = PH_PRE;
                end else if (is_num(it.ch)) begin
                    m_prio = dec_step(m_prio, it.ch);
                end else begin
                    push_beat(KIND_KEY, it.ch, m_prio);
                    if (m_nlet < MAX_LET) begin
                        m_pmem[m_nlet] = m_prio;
                        if (m_prio != 0) m_kept = m_nlet + 1;
                        m_nlet++;
                    end else begin
                        m_ovf = 1'b1;
                    end
                    m_prio = '0;
                end
            end
            PH_PRE: begin
                if (it.ch == CH_EQUAL) m_phase = PH_POST;
                else push_beat(KIND_PRE, it.ch, 8'd0);
            end
            PH_POST: begin
                if (it.ch == CH_COMMA) m_phase = PH_START;
                else push_beat(KIND_POST, it.ch, 8'd0);
            end
            PH_START: begin
                if (it.ch == CH_COMMA) m_phase = PH_CUT;
                else if (is_num(it.ch)) m_start = dec_step(m_start, it.ch);
            end
            PH_CUT: begin
                if (is_num(it.ch)) m_cut = dec_step(m_cut, it.ch);
                else m_phase = PH_STOP;
            end
            default: ;
        endcase
        if (it.last) begin
            if (m_phase == PH_KEY) close_key();
            ns  = (m_phase != PH_KEY);
            del = 0;
            skp = 0;
            if (ns) begin
                st = m_start;
                ct = m_cut;
                if (m_phase == PH_PRE || m_phase == PH_POST || m_phase == PH_START) begin
                    ct = (m_nlet >= st) ? m_nlet - st : 0;
                    if (ct > 255) ct = 255;
                end
                if (st == 0) st = 1;
                skp = ct;
                for (j = st; j < st + ct && j < m_kept; j++) begin
                    if (j - 1 <= MAX_LET && m_pmem[j - 1][0]) break;
                    del++;
                    skp--;
                end
            end
            r               = '0;
            r.kind          = KIND_SUM;
            r.prio          = m_pmem[(m_nlet > MAX_LET) ? MAX_LET : m_nlet];
            r.key_length    = m_nlet[6:0];
            r.kept_count    = m_kept[6:0];
            r.delete_before = del[6:0];
            r.skip_after    = skp[7:0];
            r.nonstandard   = ns;
            r.overflow      = m_ovf;
            r.end_mark      = 1'b1;
            exp_beats.insert(exp_beats.size(), r);
            m_phase = PH_KEY;
            m_prio  = '0;
            m_nlet  = 0;
            m_kept  = 0;
            m_start = '0;
            m_cut   = '0;
            m_ovf   = 1'b0;
        end
    endfunction

    task automatic put(logic [15:0] c);
        pat_q.insert(pat_q.size(), c);
    endtask

    task automatic commit_pattern();
        t_in_item it;
        while (pat_q.size() != 0) begin
            it.ch   = pat_q.pop_front();
            it.last = (pat_q.size() == 0);
            pend_chars.insert(pend_chars.size(), it);
        end
    endtask

    function automatic logic [15:0] pick_char(logic [15:0] avoid, logic nodig);
        logic [15:0] c;
        do begin
            case ($urandom_range(14))
                0, 1, 2, 3, 4, 5, 6, 7, 8: c = 16'h0061 + 16'($urandom_range(25));
                9, 10:  c = 16'h0041 + 16'($urandom_range(25));
                11:     c = 16'($urandom);
                12: begin
                    case ($urandom_range(4))
                        0:       c = CH_SLASH;
                        1:       c = CH_EQUAL;
                        2:       c = CH_COMMA;
                        3:       c = 16'h0000;
                        default: c = 16'hFFFF;
                    endcase
                end
                13:     c = CH_ZERO + 16'($urandom_range(9));
                default: c = {1'b1, 15'($urandom)};
            endcase
        end while (c == avoid || (nodig && is_num(c)));
        return c;
    endfunction

    task automatic put_digits(int n);
        repeat (n) put(CH_ZERO + 16'($urandom_range(9)));
    endtask

    task automatic gen_pattern();
        int nlet;
        int depth;
        if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(8, 1)) put(pick_char(CH_ZERO, 1'b0));
        end else begin
            nlet = ($urandom_range(29) == 0) ? $urandom_range(72, 60) : $urandom_range(8);
            repeat (nlet) begin
                if ($urandom_range(1)) put_digits(($urandom_range(3) == 0) ? 3 : 1);
                put(pick_char(CH_SLASH, 1'b1));
            end
            if ($urandom_range(9) < 3) put_digits($urandom_range(3, 1));
            if ($urandom_range(99) < 45) begin
                depth = $urandom_range(4);
                put(CH_SLASH);
                repeat ($urandom_range(3)) put(pick_char(CH_EQUAL, 1'b0));
                if (depth >= 1) begin
                    put(CH_EQUAL);
                    repeat ($urandom_range(3)) put(pick_char(CH_COMMA, 1'b0));
                end
                if (depth >= 2) begin
                    put(CH_COMMA);
                    if ($urandom_range(3) == 0) put(pick_char(CH_COMMA, 1'b1));
                    put_digits(($urandom_range(5) == 0) ? 3 : $urandom_range(1));
                end
                if (depth >= 3) begin
                    put(CH_COMMA);
                    put_digits(($urandom_range(5) == 0) ? 3 : $urandom_range(2));
                end
                if (depth >= 4) begin
                    put(pick_char(CH_SLASH, 1'b1));
                    repeat ($urandom_range(3)) put(pick_char(CH_SLASH, 1'b0));
                end
            end
        end
        if (pat_q.size() == 0) put(pick_char(CH_SLASH, 1'b1));
        commit_pattern();
    endtask

    task automatic chk(string fld, logic [15:0] e, logic [15:0] a);
        if (e !== a) begin
            n_err++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, fld, e, a);
        end
    endtask

    always @(posedge i_clk) begin
        logic take;
        int   burst;
        if (!i_rst_n) begin
            start  <= 1'b0;
            i_data <= '0;
            gap    <= 0;
        end else begin
            take  = start && !busy;
            burst = gap;
            if (take) begin
                parse_char(i_data);
                n_taken++;
                if (n_taken % 64 == 0) begin
                    case ($urandom_range(2))
                        0:       gap_pct = 0;
                        1:       gap_pct = 15;
                        default: gap_pct = 45;
                    endcase
                end
                if (pend_chars.size() > TAIL_LEN && $urandom_range(99) < gap_pct)
                    burst = $urandom_range(16, 1);
            end
            if (take || !start) begin
                if (burst > 0) begin
                    start <= 1'b0;
                    gap   <= burst - 1;
                end else if (pend_chars.size() != 0) begin
                    start  <= 1'b1;
                    i_data <= pend_chars.pop_front();
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_out_item want;
        if (i_rst_n && o_strobe === 1'b1) begin
            if (exp_beats.size() == 0) begin
                n_err++;
                $display("%0t: unexpected beat, expected none actual %h", $time, o_result);
            end else begin
                want = exp_beats.pop_front();
                chk("kind",          16'(want.kind),          16'(o_result.kind));
                chk("out_char",      want.out_char,           o_result.out_char);
                chk("prio",          16'(want.prio),          16'(o_result.prio));
                chk("key_length",    16'(want.key_length),    16'(o_result.key_length));
                chk("kept_count",    16'(want.kept_count),    16'(o_result.kept_count));
                chk("delete_before", 16'(want.delete_before), 16'(o_result.delete_before));
                chk("skip_after",    16'(want.skip_after),    16'(o_result.skip_after));
                chk("nonstandard",   16'(want.nonstandard),   16'(o_result.nonstandard));
                chk("overflow",      16'(want.overflow),      16'(o_result.overflow));
                chk("end_mark",      16'(want.end_mark),      16'(o_result.end_mark));
            end
        end
    end

    initial begin
        put(CH_ZERO + 16'd1); put(16'h0000);
        put(CH_ZERO + 16'd9); put(CH_ZERO + 16'd9); put(CH_ZERO + 16'd9);
        put(16'hFFFF); put(CH_ZERO + 16'd3);
        commit_pattern();
        put(16'h0061); put(CH_ZERO); put(16'h0062); put(16'h0063);
        commit_pattern();
        put(16'h0061); put(CH_ZERO + 16'd2); put(16'h0062); put(CH_SLASH);
        put(16'h0078); put(CH_EQUAL); put(16'h0079); put(CH_COMMA);
        put(CH_ZERO); put(16'h007A); put(CH_COMMA); put(CH_ZERO + 16'd9);
        put(16'h0071); put(16'h0072);
        commit_pattern();
        while (pend_chars.size() < 550) gen_pattern();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pend_chars.size() != 0 || start) @(posedge i_clk);
        while (exp_beats.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);

        if (exp_beats.size() != 0) begin
            n_err++;
            $display("%0t: %0d expected beats never arrived", $time, exp_beats.size());
        end
        if (n_err == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule
